/* rtl/pph_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pulse period histogram.
// No dependencies; imported by the top level (pph_ram does not use it).
package pph_pkg;

    // Histogram geometry
    localparam int BINS       = 101;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_W     = (BINS > 1) ? $clog2(BINS) : 1;

    localparam logic [31:0]           BINS_W    = 32'(BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 7;
    localparam int MEAS_W   = 16;
    localparam int BINVAL_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_COUNT = 2'd1;

    localparam logic [TIME_W-1:0] WINDOW_LOW_RST    = 32'd950;
    localparam logic [MEAS_W-1:0] MEASURE_COUNT_RST = 16'd1001;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TIME_W-1:0] capture_time;
        logic [IDX_W-1:0]  bin_index;
    } pph_in_t;

    typedef struct packed {
        logic [TIME_W-1:0]   period;
        logic                period_valid;
        logic                in_window;
        logic                run_done;
        logic [BINVAL_W-1:0] bin_value;
    } pph_out_t;

endpackage

/* rtl/pph_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; read-during-write to one address returns the old word.
module pph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pulse_period_histogram.sv */
`timescale 1ns / 1ps
// Top level of the input-capture period histogram.
// Depends on pph_pkg and pph_ram (histogram bin storage).
//
//  channel  | direction | handshake             | beat content
//  ---------+-----------+-----------------------+------------------------------------
//  s_       | in        | s_valid / s_ready     | pph_in_t: operation, time, bin index
//  m_       | out       | m_valid / m_ready     | pph_out_t: period, flags, bin value
//  cfg_     | in        | cfg_valid / cfg_ready | register index, write data
//
// One beat per cycle in and out while m_ready is high; a result passes stage 1, stage 2 and the result register.
// Run state (previous time, measured count, running) updates on the accepting edge;
// stage 1 places the period in the window, stage 2 does the bin read-modify-write.
// Reset and a start beat clear the histogram at once through per-bin valid bits.
// A stall on m_ready backs up through the stages; s_ready drops only when all are full.
module pulse_period_histogram (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  pph_pkg::pph_in_t                        s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output pph_pkg::pph_out_t                       m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pph_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [pph_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import pph_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] window_low_reg;
    logic [MEAS_W-1:0] measure_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg    <= WINDOW_LOW_RST;
            measure_count_reg <= MEASURE_COUNT_RST;
        end else if (cfg_valid) begin
            // Writes beyond the register list are dropped
            if (cfg_index == REG_WINDOW_LOW) begin
                window_low_reg <= cfg_data[TIME_W-1:0];
            end else if (cfg_index == REG_MEASURE_COUNT) begin
                measure_count_reg <= cfg_data[MEAS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: each stage advances when the next can take it
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_ld, s2_ld, s2_go, s1_ld, s1_go, acc;

    assign out_ld  = !m_valid_reg || m_ready;
    assign s2_go   = s2_valid_reg && out_ld;
    assign s2_ld   = !s2_valid_reg || out_ld;
    assign s1_go   = s1_valid_reg && s2_ld;
    assign s1_ld   = !s1_valid_reg || s2_ld;
    assign s_ready = s1_ld;
    assign acc     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Accept stage: run state and period
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic              have_prev_reg, have_prev_next;
    logic [MEAS_W-1:0] measured_reg, measured_next;
    logic              running_reg, running_next;

    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] a_period;
    logic              a_pvalid;
    logic              a_start;
    logic              a_read;
    logic [ADDR_W-1:0] a_addr;

    assign diff = s_data.capture_time - prev_time_reg;

    always_comb begin
        prev_time_next = prev_time_reg;
        have_prev_next = have_prev_reg;
        measured_next  = measured_reg;
        running_next   = running_reg;
        a_period       = '0;
        a_pvalid       = 1'b0;
        a_start        = 1'b0;
        a_read         = 1'b0;
        a_addr         = '0;
        if (acc) begin
            unique case (s_data.operation)
                OP_START: begin
                    have_prev_next = 1'b0;
                    measured_next  = '0;
                    running_next   = 1'b1;
                    a_start        = 1'b1;
                end
                OP_CAPTURE: begin
                    if (running_reg) begin
                        prev_time_next = s_data.capture_time;
                        have_prev_next = 1'b1;
                        if (have_prev_reg) begin
                            a_period = diff;
                            a_pvalid = 1'b1;
                            // hold at full scale
                            if (measured_reg != '1) begin
                                measured_next = measured_reg + 1'b1;
                            end
                            if (measured_next >= measure_count_reg) begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (32'(s_data.bin_index) < BINS_W) begin
                        a_read = 1'b1;
                        a_addr = ADDR_W'(s_data.bin_index);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
            measured_reg  <= '0;
            running_reg   <= 1'b0;
        end else begin
            prev_time_reg <= prev_time_next;
            have_prev_reg <= have_prev_next;
            measured_reg  <= measured_next;
            running_reg   <= running_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window check, issue the bin read
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] s1_period_reg;
    logic              s1_pvalid_reg;
    logic              s1_start_reg;
    logic              s1_read_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_done_reg;

    logic [TIME_W:0]   off;
    logic              s1_inwin;
    logic [ADDR_W-1:0] s1_addr;

    // The window never wraps: a borrow means the period is below the window base
    assign off      = {1'b0, s1_period_reg} - {1'b0, window_low_reg};
    assign s1_inwin = s1_pvalid_reg && !off[TIME_W] && (off[TIME_W-1:0] < BINS_W);
    assign s1_addr  = s1_inwin ? ADDR_W'(off[TIME_W-1:0]) : s1_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ld) begin
            s1_valid_reg <= acc;
        end
        if (s1_ld) begin
            s1_period_reg <= a_period;
            s1_pvalid_reg <= a_pvalid;
            s1_start_reg  <= a_start;
            s1_read_reg   <= a_read;
            s1_addr_reg   <= a_addr;
            s1_done_reg   <= !running_next && (measured_next != '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: bin read-modify-write
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]     s2_period_reg;
    logic                  s2_pvalid_reg;
    logic                  s2_inwin_reg;
    logic                  s2_start_reg;
    logic                  s2_read_reg;
    logic [ADDR_W-1:0]     s2_addr_reg;
    logic                  s2_done_reg;

    logic [BINS-1:0]       vbit_reg, vbit_next;
    logic                  fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [COUNT_BITS-1:0] ram_q;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] upd;
    logic                  wr_en;

    pph_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (upd),
        .rd_en   (s1_go),
        .rd_addr (s1_addr),
        .rd_data (ram_q)
    );

    // Latest write wins over the RAM word; a bin not written since the last
    // clear reads as zero
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) begin
            cur = fwd_data_reg;
        end else if (vbit_reg[s2_addr_reg]) begin
            cur = ram_q;
        end else begin
            cur = '0;
        end
    end

    assign upd   = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    assign wr_en = s2_go && s2_inwin_reg;

    always_comb begin
        vbit_next      = vbit_reg;
        fwd_valid_next = fwd_valid_reg;
        if (s2_go) begin
            if (s2_start_reg) begin
                vbit_next      = '0;
                fwd_valid_next = 1'b0;
            end else if (s2_inwin_reg) begin
                vbit_next[s2_addr_reg] = 1'b1;
                fwd_valid_next         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            vbit_reg      <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s2_ld) begin
                s2_valid_reg <= s1_valid_reg;
            end
            vbit_reg      <= vbit_next;
            fwd_valid_reg <= fwd_valid_next;
        end
        if (s1_go) begin
            s2_period_reg <= s1_period_reg;
            s2_pvalid_reg <= s1_pvalid_reg;
            s2_inwin_reg  <= s1_inwin;
            s2_start_reg  <= s1_start_reg;
            s2_read_reg   <= s1_read_reg;
            s2_addr_reg   <= s1_addr;
            s2_done_reg   <= s1_done_reg;
        end
        if (wr_en) begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= upd;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    pph_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ld) begin
            m_valid_reg <= s2_valid_reg;
        end
        if (s2_go) begin
            m_data_reg.period       <= s2_period_reg;
            m_data_reg.period_valid <= s2_pvalid_reg;
            m_data_reg.in_window    <= s2_inwin_reg;
            m_data_reg.run_done     <= s2_done_reg;
            m_data_reg.bin_value    <= s2_read_reg ? BINVAL_W'(cur) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
